[rtl/oslt_pkg.sv]
package oslt_pkg;

  // Command classes handed from the front to the back
  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,  // query whose live state does not match
    CMD_QUERY = 2'd1,  // matching query: refresh or register
    CMD_TICK  = 2'd2   // frame tick: age and free entries
  } cmd_e;

  localparam int unsigned KindW = 2;
  localparam int unsigned CodeW = 9;

  // Command word carried through the queue
  typedef struct packed {
    cmd_e             cmd;
    logic [KindW-1:0] kind;
    logic [CodeW-1:0] code;
    logic             pol;
  } cmd_t;

  // Command queue depth and pointer width
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;

endpackage

[rtl/oslt_front.sv]
module oslt_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         operation_i,
  input  logic [oslt_pkg::KindW-1:0]   device_kind_i,
  input  logic [oslt_pkg::CodeW-1:0]   button_code_i,
  input  logic                         want_pressed_i,
  input  logic                         live_matches_i,
  input  logic                         q_full_i,
  output logic                         busy_o,
  output logic                         push_o,
  output oslt_pkg::cmd_t               push_cmd_o
);
  import oslt_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic accept;

  // Hold off the issuer only while the staged word cannot drain
  assign busy_o     = valid_q & q_full_i;
  assign accept     = start_i & ~busy_o;
  assign push_o     = valid_q & ~q_full_i;
  assign push_cmd_o = cmd_q;

  // Classify the incoming word
  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (accept) begin
      valid_d   = 1'b1;
      cmd_d.kind = device_kind_i;
      cmd_d.code = button_code_i;
      cmd_d.pol  = want_pressed_i;
      if (operation_i) begin
        cmd_d.cmd = CMD_TICK;
      end else if (live_matches_i) begin
        cmd_d.cmd = CMD_QUERY;
      end else begin
        cmd_d.cmd = CMD_NOP;
      end
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Staged payload, no reset needed
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

[rtl/oslt_queue.sv]
module oslt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  oslt_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output oslt_pkg::cmd_t pop_cmd_o
);
  import oslt_pkg::*;

  localparam int unsigned CntW = QueuePtrW + 1;

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]      cnt_q;
  logic                 do_push, do_pop;

  assign full_o    = (cnt_q == CntW'(QueueDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i & ~full_o;
  assign do_pop    = pop_i & ~empty_o;
  assign pop_cmd_o = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[rtl/oslt_back.sv]
module oslt_back #(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  oslt_pkg::cmd_t q_cmd_i,
  output logic           pop_o,
  output logic           result_valid_o,
  output logic           fired_o,
  output logic           table_full_o
);
  import oslt_pkg::*;

  // Slot storage: one register row per slot
  logic [TABLE_SLOTS-1:0] used_q, used_d;
  logic [TABLE_SLOTS-1:0] stale_q, stale_d;
  logic [KindW-1:0]       kind_q [TABLE_SLOTS];
  logic [CodeW-1:0]       code_q [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] pol_q;

  logic [TABLE_SLOTS-1:0] hit;
  logic [TABLE_SLOTS-1:0] ins_sel;
  logic                   any_hit, any_free;
  logic                   do_query, do_tick, do_insert;
  logic                   valid_d, fired_d, full_d;

  // One word per cycle whenever the queue holds one
  assign pop_o     = ~q_empty_i;
  assign do_query  = pop_o & (q_cmd_i.cmd == CMD_QUERY);
  assign do_tick   = pop_o & (q_cmd_i.cmd == CMD_TICK);

  // Parallel match and highest free slot
  always_comb begin
    logic found;
    found   = 1'b0;
    ins_sel = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      hit[i] = used_q[i] & (kind_q[i] == q_cmd_i.kind) &
               (code_q[i] == q_cmd_i.code) & (pol_q[i] == q_cmd_i.pol);
    end
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i] && !found) begin
        ins_sel[i] = 1'b1;
        found      = 1'b1;
      end
    end
  end

  assign any_hit   = |hit;
  assign any_free  = ~&used_q;
  assign do_insert = do_query & ~any_hit & any_free;

  // Next table flags
  always_comb begin
    used_d  = used_q;
    stale_d = stale_q;
    if (do_tick) begin
      used_d  = used_q & ~stale_q;
      stale_d = stale_q | used_q;
    end else if (do_query) begin
      if (any_hit) begin
        stale_d = stale_q & ~hit;
      end else if (any_free) begin
        used_d  = used_q | ins_sel;
        stale_d = stale_q & ~ins_sel;
      end
    end
  end

  // Result word
  assign valid_d = pop_o;
  assign fired_d = do_insert;
  assign full_d  = do_query & ~any_hit & ~any_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q         <= '0;
      result_valid_o <= 1'b0;
      fired_o        <= 1'b0;
      table_full_o   <= 1'b0;
    end else begin
      used_q         <= used_d;
      result_valid_o <= valid_d;
      fired_o        <= fired_d;
      table_full_o   <= full_d;
    end
  end

  // Entry payload, written on insert only, and the unreset stale flags
  always_ff @(posedge clk_i) begin
    stale_q <= stale_d;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (do_insert && ins_sel[i]) begin
        kind_q[i] <= q_cmd_i.kind;
        code_q[i] <= q_cmd_i.code;
        pol_q[i]  <= q_cmd_i.pol;
      end
    end
  end

endmodule

[rtl/one_shot_input_latch_table.sv]
// Channel   Direction  Handshake                  Word
// command   in         start_i high, busy_o low   operation, device_kind, button_code,
//                                                 want_pressed, live_matches
// result    out        result_valid_o, 1 cycle    fired, table_full
//
// Every command gives one result. A command is held in the staging register,
// queued (two entries), then run against the slot table and its result
// registered; one command per cycle is sustained while busy_o is low. The
// parallel match over all slots plus write-back sets the pace. busy_o rises
// only when the staging register and the queue are both full. Reset clears
// the slot valid flags at once; no clearing pass. Results cannot be stalled.
module one_shot_input_latch_table #(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       operation_i,
  input  logic [oslt_pkg::KindW-1:0] device_kind_i,
  input  logic [oslt_pkg::CodeW-1:0] button_code_i,
  input  logic                       want_pressed_i,
  input  logic                       live_matches_i,
  output logic                       result_valid_o,
  output logic                       fired_o,
  output logic                       table_full_o
);
  import oslt_pkg::*;

  logic push, q_full, q_empty, pop;
  cmd_t push_cmd, pop_cmd;

  // Accept and classify
  oslt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .operation_i    (operation_i),
    .device_kind_i  (device_kind_i),
    .button_code_i  (button_code_i),
    .want_pressed_i (want_pressed_i),
    .live_matches_i (live_matches_i),
    .q_full_i       (q_full),
    .busy_o         (busy_o),
    .push_o         (push),
    .push_cmd_o     (push_cmd)
  );

  // Decoupling queue
  oslt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .pop_cmd_o  (pop_cmd)
  );

  // Slot table and result
  oslt_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_cmd_i        (pop_cmd),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .fired_o        (fired_o),
    .table_full_o   (table_full_o)
  );

endmodule
